/* sv/xkb64_pkg.sv */
// Shared types, constants and the sextet-to-character map for the keyed Base64 encoder.
`default_nettype none

package xkb64_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_end;
	} out_beat_t;

	typedef logic [1:0] phase_t;

	localparam phase_t PHASE_FIRST  = 2'd0;
	localparam phase_t PHASE_SECOND = 2'd1;
	localparam phase_t PHASE_THIRD  = 2'd2;

	localparam logic [1:0] CFG_KEY_FIRST  = 2'd0;
	localparam logic [1:0] CFG_KEY_SECOND = 2'd1;
	localparam logic [1:0] CFG_KEY_THIRD  = 2'd2;

	localparam logic [7:0] KEY_FIRST_RST  = 8'd75;
	localparam logic [7:0] KEY_SECOND_RST = 8'd67;
	localparam logic [7:0] KEY_THIRD_RST  = 8'd81;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			sextet_char = w + 8'h41;
		end else if (v < 6'd52) begin
			sextet_char = w + 8'h47;
		end else if (v < 6'd62) begin
			sextet_char = w - 8'h04;
		end else if (v == 6'd62) begin
			sextet_char = 8'h2b;
		end else begin
			sextet_char = 8'h2f;
		end
	endfunction

endpackage

`default_nettype wire

/* sv/xor_key_base64_encoder_unit.sv */
// Top level of the keyed Base64 encoder: key registers, group assembly and character emitter.
//
//  channel | signals                               | direction | beat
//  byte    | byte_valid, byte_stall, byte_beat      | in        | one message byte + last mark
//  char    | char_valid, char_stall, char_beat      | out       | one character + end mark
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in     | one key register write
//
// Non-completing bytes are taken without stall; a byte that completes a group
// (third of a group or marked last) loads four characters into the emitter.
// The emitter sends one character per cycle while char_stall is low, and can take
// the next group's characters as the last character of the previous group leaves.
// A completing byte is stalled only while the emitter still holds characters that
// will not leave this cycle. Reset clears the phase and the emitter and loads the reset keys.
`default_nettype none

module xor_key_base64_encoder_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	output logic                     byte_stall,
	input  wire xkb64_pkg::in_beat_t byte_beat,
	output logic                     char_valid,
	input  wire logic                char_stall,
	output xkb64_pkg::out_beat_t     char_beat,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [7:0]          cfg_data
);

	logic [7:0]        key_first_q, key_second_q, key_third_q;
	xkb64_pkg::phase_t phase_q;
	logic [7:0]        pend_q [2];
	logic [7:0]        chars_q [4];
	logic [1:0]        idx_q;
	logic              busy_q;
	logic              fin_q;

	logic [7:0]  key;
	logic [7:0]  xb;
	logic        completes;
	logic        byte_accept;
	logic        emit_free;
	logic        load;
	logic [7:0]  b0, b1, b2;
	logic [23:0] word;
	logic        pad2, pad3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_first_q  <= xkb64_pkg::KEY_FIRST_RST;
			key_second_q <= xkb64_pkg::KEY_SECOND_RST;
			key_third_q  <= xkb64_pkg::KEY_THIRD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				xkb64_pkg::CFG_KEY_FIRST:  key_first_q  <= cfg_data;
				xkb64_pkg::CFG_KEY_SECOND: key_second_q <= cfg_data;
				xkb64_pkg::CFG_KEY_THIRD:  key_third_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (phase_q)
			xkb64_pkg::PHASE_SECOND: key = key_second_q;
			xkb64_pkg::PHASE_THIRD:  key = key_third_q;
			default:                 key = key_first_q;
		endcase
	end

	assign xb        = byte_beat.data_byte ^ key;
	assign completes = (phase_q == xkb64_pkg::PHASE_THIRD) || byte_beat.final_byte;
	assign emit_free = !busy_q || ((idx_q == 2'd3) && !char_stall);
	assign byte_stall  = completes && !emit_free;
	assign byte_accept = byte_valid && !byte_stall;
	assign load        = byte_accept && completes;

	always_comb begin
		unique case (phase_q)
			xkb64_pkg::PHASE_SECOND: begin
				b0 = pend_q[0];
				b1 = xb;
				b2 = 8'h00;
			end
			xkb64_pkg::PHASE_THIRD: begin
				b0 = pend_q[0];
				b1 = pend_q[1];
				b2 = xb;
			end
			default: begin
				b0 = xb;
				b1 = 8'h00;
				b2 = 8'h00;
			end
		endcase
	end

	assign word = {b0, b1, b2};
	assign pad2 = (phase_q != xkb64_pkg::PHASE_SECOND) && (phase_q != xkb64_pkg::PHASE_THIRD);
	assign pad3 = phase_q != xkb64_pkg::PHASE_THIRD;

	// hold the pending bytes of the open group
	always_ff @(posedge clk) begin
		if (byte_accept && !completes) begin
			if (phase_q == xkb64_pkg::PHASE_SECOND) begin
				pend_q[1] <= xb;
			end else begin
				pend_q[0] <= xb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= xkb64_pkg::PHASE_FIRST;
		end else if (byte_accept) begin
			if (completes) begin
				phase_q <= xkb64_pkg::PHASE_FIRST;
			end else if (phase_q == xkb64_pkg::PHASE_SECOND) begin
				phase_q <= xkb64_pkg::PHASE_THIRD;
			end else begin
				phase_q <= xkb64_pkg::PHASE_SECOND;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q[0] <= xkb64_pkg::sextet_char(word[23:18]);
			chars_q[1] <= xkb64_pkg::sextet_char(word[17:12]);
			chars_q[2] <= pad2 ? xkb64_pkg::PAD_CHAR : xkb64_pkg::sextet_char(word[11:6]);
			chars_q[3] <= pad3 ? xkb64_pkg::PAD_CHAR : xkb64_pkg::sextet_char(word[5:0]);
			fin_q      <= byte_beat.final_byte;
		end
	end

	// advance the emitter one character per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (busy_q && !char_stall) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign char_valid         = busy_q;
	assign char_beat.out_char = chars_q[idx_q];
	assign char_beat.run_end  = fin_q && (idx_q == 2'd3);

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> emit_free)
		else $error("group loaded while emitter busy");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("group phase out of range");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && char_beat.run_end) |-> (idx_q == 2'd3))
		else $error("end mark away from fourth character");

	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_accept && byte_beat.final_byte) |=> (phase_q == xkb64_pkg::PHASE_FIRST))
		else $error("phase not cleared after last byte");

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (char_valid && (idx_q == 2'd0)))
		else $error("loaded group not presented");

endmodule

`default_nettype wire

/* sim/xkb64_char_checker.sv */
// Watches the keyed Base64 encoder's channels, predicts its characters and compares them.
module xkb64_char_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic                 byte_stall,
	input  xkb64_pkg::in_beat_t  byte_beat,
	input  logic                 char_valid,
	input  logic                 char_stall,
	input  xkb64_pkg::out_beat_t char_beat,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	output int unsigned          fail_count,
	output int unsigned          chars_owed,
	output int unsigned          chars_checked
);

	localparam logic [511:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	logic [7:0]           xor_key [3];
	logic [7:0]           held_bytes [2];
	xkb64_pkg::phase_t    grp_pos;
	xkb64_pkg::out_beat_t char_expect [$];

	function automatic logic [7:0] b64_of(input logic [5:0] v);
		return ALPHABET[8 * (63 - int'(v)) +: 8];
	endfunction

	task automatic encode_byte(input xkb64_pkg::in_beat_t b);
		logic [7:0]           k;
		logic [7:0]           x;
		logic [23:0]          grp;
		int                   n;
		xkb64_pkg::out_beat_t c;
		if (grp_pos == xkb64_pkg::PHASE_SECOND) begin
			k = xor_key[1];
		end else if (grp_pos == xkb64_pkg::PHASE_THIRD) begin
			k = xor_key[2];
		end else begin
			k = xor_key[0];
		end
		x = b.data_byte ^ k;
		if (grp_pos != xkb64_pkg::PHASE_THIRD && !b.final_byte) begin
			if (grp_pos == xkb64_pkg::PHASE_SECOND) begin
				held_bytes[1] = x;
				grp_pos = xkb64_pkg::PHASE_THIRD;
			end else begin
				held_bytes[0] = x;
				grp_pos = xkb64_pkg::PHASE_SECOND;
			end
		end else begin
			case (grp_pos)
				xkb64_pkg::PHASE_SECOND: begin
					grp = {held_bytes[0], x, 8'h00};
					n = 3;
				end
				xkb64_pkg::PHASE_THIRD: begin
					grp = {held_bytes[0], held_bytes[1], x};
					n = 4;
				end
				default: begin
					grp = {x, 16'h0000};
					n = 2;
				end
			endcase
			for (int i = 0; i < 4; i++) begin
				c.out_char = (i < n) ? b64_of(grp[23 - 6 * i -: 6]) : xkb64_pkg::PAD_CHAR;
				c.run_end = (i == 3) && b.final_byte;
				char_expect.push_back(c);
			end
			grp_pos = xkb64_pkg::PHASE_FIRST;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		xkb64_pkg::out_beat_t e;
		if (!arst_n) begin
			xor_key[0] = xkb64_pkg::KEY_FIRST_RST;
			xor_key[1] = xkb64_pkg::KEY_SECOND_RST;
			xor_key[2] = xkb64_pkg::KEY_THIRD_RST;
			held_bytes[0] = 8'h00;
			held_bytes[1] = 8'h00;
			grp_pos = xkb64_pkg::PHASE_FIRST;
			char_expect.delete();
			fail_count = 0;
			chars_checked = 0;
			chars_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					xkb64_pkg::CFG_KEY_FIRST:  xor_key[0] = cfg_data;
					xkb64_pkg::CFG_KEY_SECOND: xor_key[1] = cfg_data;
					xkb64_pkg::CFG_KEY_THIRD:  xor_key[2] = cfg_data;
					default: ;
				endcase
			end
			if (byte_valid && !byte_stall) begin
				encode_byte(byte_beat);
			end
			if (char_valid && !char_stall) begin
				if (char_expect.size() == 0) begin
					$error("unexpected beat: out_char %h run_end %b",
						char_beat.out_char, char_beat.run_end);
					fail_count++;
				end else begin
					e = char_expect.pop_front();
					if (char_beat.out_char !== e.out_char) begin
						$error("out_char: expected %h, actual %h", e.out_char, char_beat.out_char);
						fail_count++;
					end
					if (char_beat.run_end !== e.run_end) begin
						$error("run_end: expected %b, actual %b", e.run_end, char_beat.run_end);
						fail_count++;
					end
					chars_checked++;
				end
			end
			chars_owed <= char_expect.size();
		end
	end

endmodule

/* sim/tb_xor_key_base64_encoder_unit.sv */
// Stimulus, idling and verdict for the keyed Base64 encoder top level.
module tb_xor_key_base64_encoder_unit;

	localparam int QUIET_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	xkb64_pkg::in_beat_t  byte_beat = '0;
	logic                 char_valid;
	logic                 char_stall = 1'b0;
	xkb64_pkg::out_beat_t char_beat;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [1:0]           cfg_index = xkb64_pkg::CFG_KEY_FIRST;
	logic [7:0]           cfg_data = 8'h00;

	int unsigned fail_count;
	int unsigned chars_owed;
	int unsigned chars_checked;

	int          burst_left = 0;
	logic        steady = 1'b0;
	int unsigned hold_asked = 0;
	int unsigned hold_served = 0;
	int          hold_left = 0;
	int          seg_left = 0;
	int          stall_mode = 0;
	int          quiet = 0;
	int          bytes_sent = 0;
	int          msgs_sent = 0;
	int          key_sets = 0;
	logic [7:0]  run_bytes [$];

	always #10 clk = ~clk;

	xor_key_base64_encoder_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	xkb64_char_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_beat     (byte_beat),
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_beat     (char_beat),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.chars_owed    (chars_owed),
		.chars_checked (chars_checked)
	);

	task automatic send_byte(input logic [7:0] d, input logic f);
		int gap;
		if (!steady && burst_left <= 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_beat <= {d, f};
		do @(posedge clk); while (byte_stall);
		bytes_sent++;
		if (f) begin
			msgs_sent++;
		end
	endtask

	task automatic send_run();
		foreach (run_bytes[i]) begin
			send_byte(run_bytes[i], i == run_bytes.size() - 1);
		end
	endtask

	task automatic send_random_msg(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), i == len - 1);
		end
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		do @(posedge clk); while (chars_owed != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_key(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_keys(input logic [7:0] k0, input logic [7:0] k1, input logic [7:0] k2);
		write_key(xkb64_pkg::CFG_KEY_FIRST, k0);
		write_key(xkb64_pkg::CFG_KEY_SECOND, k1);
		write_key(xkb64_pkg::CFG_KEY_THIRD, k2);
		cfg_valid <= 1'b0;
		key_sets++;
	endtask

	// receiver: long hold-off on request, otherwise segments of varying stall patterns
	always @(posedge clk) begin
		if (hold_left > 0) begin
			char_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_served + 1;
			hold_left <= 80;
			char_stall <= 1'b1;
		end else begin
			if (seg_left <= 0) begin
				stall_mode <= $urandom_range(0, 3);
				seg_left <= $urandom_range(8, 40);
			end else begin
				seg_left <= seg_left - 1;
			end
			case (stall_mode)
				0: char_stall <= 1'b0;
				1: char_stall <= ($urandom_range(0, 3) == 0);
				2: char_stall <= ($urandom_range(0, 3) != 0);
				default: char_stall <= ~char_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (char_valid && !char_stall) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("** xor_key_base64_encoder_unit: FAILED **");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		int phase_bytes;
		int len;
		logic [7:0] key_tab [5][3];
		key_tab[0] = '{8'h00, 8'h00, 8'h00};
		key_tab[1] = '{8'hff, 8'hff, 8'hff};
		key_tab[2] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))};
		key_tab[3] = '{8'h80, 8'h01, 8'h7f};
		key_tab[4] = '{8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255))};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset keys: lone byte, two-byte tail, zero and all-ones groups, aligned end
		run_bytes = '{8'h00};
		send_run();
		run_bytes = '{8'hff, 8'h80};
		send_run();
		run_bytes = '{xkb64_pkg::KEY_FIRST_RST, xkb64_pkg::KEY_SECOND_RST,
			xkb64_pkg::KEY_THIRD_RST};
		send_run();
		run_bytes = '{~xkb64_pkg::KEY_FIRST_RST, ~xkb64_pkg::KEY_SECOND_RST,
			~xkb64_pkg::KEY_THIRD_RST};
		send_run();
		run_bytes = '{8'h00, 8'hff, 8'h00, 8'hff, 8'h00, 8'hff};
		send_run();
		run_bytes = '{8'h12, 8'h34, 8'h56, 8'h78};
		send_run();
		drain();

		for (int p = 0; p < 5; p++) begin
			program_keys(key_tab[p][0], key_tab[p][1], key_tab[p][2]);
			phase_bytes = 0;
			if (p == 1) begin
				hold_asked <= hold_asked + 1;
				steady = 1'b1;
				send_random_msg(15);
				steady = 1'b0;
				phase_bytes = 15;
			end
			while (phase_bytes < 40) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
				send_random_msg(len);
				phase_bytes += len;
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("covered %0d bytes in %0d messages over %0d key settings plus reset keys",
			bytes_sent, msgs_sent, key_sets);
		$display("%0d characters checked, %0d mismatches", chars_checked, fail_count);
		if (fail_count == 0) begin
			$display("** xor_key_base64_encoder_unit: PASSED **");
		end else begin
			$display("** xor_key_base64_encoder_unit: FAILED **");
		end
		$finish;
	end

endmodule
